### rtl/core/rmdi_pkg.sv
// Package for the relay motor direction interlock.
// Holds the codes, request and result types and reset constants.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rmdi_pkg;

    localparam int unsigned DELAY_W = 16;
    localparam logic [DELAY_W-1:0] SWITCH_DELAY_RST = 16'd100;
    localparam logic RELAY_ACTIVE_HIGH_RST = 1'b1;
    localparam int unsigned CFG_DATA_W = DELAY_W;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        CMD_RUN  = 2'd0,
        CMD_STOP = 2'd1,
        CMD_TICK = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        MODE_STOPPED   = 2'd0,
        MODE_SWITCHING = 2'd1,
        MODE_RUNNING   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PARAM = 2'd1,
        ST_BUSY  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SWITCH_DELAY      = 1'd0,
        CFG_RELAY_ACTIVE_HIGH = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] direction;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic       relay_cw_level;
        logic       relay_ccw_level;
        logic [1:0] motor_state;
        logic [1:0] active_dir;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/rmdi_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on rmdi_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface rmdi_request_if;
    logic               valid;
    logic               ready;
    rmdi_pkg::request_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rmdi_result_if;
    logic              valid;
    logic              ready;
    rmdi_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/relay_motor_direction_interlock_unit.sv
// Top level of the relay motor direction interlock (break-before-make control).
// Depends on rmdi_pkg and on the channel interfaces in rmdi_if.sv.
//
//   Channel   Direction   Payload
//   request   in          command, direction
//   result    out         status, relay levels, motor_state, active_dir
//   cfg_*     in          switch_delay (index 0), relay_active_high (index 1)
//
// Each request's result is registered when the request is taken and is valid in the cycle after.
// A new request is taken every cycle while the result register is empty or drained.
// A stalled result holds the result register and the request channel waits.
// Reset clears the motor state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module relay_motor_direction_interlock_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rmdi_request_if.sink                           request,
    rmdi_result_if.source                          result,
    input  wire logic                              cfg_we,
    input  wire logic [rmdi_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rmdi_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [rmdi_pkg::DELAY_W-1:0] switch_delay_reg;
    logic                         relay_active_high_reg;

    rmdi_pkg::mode_t              mode_reg, mode_next;
    rmdi_pkg::dir_t               current_dir_reg, current_dir_next;
    rmdi_pkg::dir_t               pending_dir_reg, pending_dir_next;
    logic [rmdi_pkg::DELAY_W-1:0] ticks_left_reg, ticks_left_next;

    logic                         res_valid_reg;
    rmdi_pkg::result_t            res_reg, res_next;

    logic                         accept;
    rmdi_pkg::status_t            status;
    rmdi_pkg::dir_t               energized;
    logic                         dir_ok;
    logic [rmdi_pkg::DELAY_W-1:0] ticks_dec;

    assign request.ready  = !res_valid_reg || result.ready;
    assign accept         = request.valid && request.ready;
    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_delay_reg      <= rmdi_pkg::SWITCH_DELAY_RST;
            relay_active_high_reg <= rmdi_pkg::RELAY_ACTIVE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (rmdi_pkg::cfg_index_t'(cfg_index))
                rmdi_pkg::CFG_SWITCH_DELAY:      switch_delay_reg <= cfg_data;
                rmdi_pkg::CFG_RELAY_ACTIVE_HIGH: relay_active_high_reg <= cfg_data[0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        current_dir_next = current_dir_reg;
        pending_dir_next = pending_dir_reg;
        ticks_left_next  = ticks_left_reg;
        status           = rmdi_pkg::ST_OK;
        dir_ok           = (request.payload.direction == rmdi_pkg::DIR_CW) ||
                           (request.payload.direction == rmdi_pkg::DIR_CCW);
        ticks_dec        = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : ticks_left_reg;

        case (rmdi_pkg::command_t'(request.payload.command))
            rmdi_pkg::CMD_RUN:
            begin
                if (!dir_ok)
                begin
                    status = rmdi_pkg::ST_PARAM;
                end
                else if (mode_reg == rmdi_pkg::MODE_SWITCHING)
                begin
                    status = rmdi_pkg::ST_BUSY;
                end
                else if (!(mode_reg == rmdi_pkg::MODE_RUNNING &&
                           current_dir_reg == rmdi_pkg::dir_t'(request.payload.direction)))
                begin
                    pending_dir_next = rmdi_pkg::dir_t'(request.payload.direction);
                    ticks_left_next  = (current_dir_reg != rmdi_pkg::DIR_NONE) ?
                                       switch_delay_reg : '0;
                    mode_next        = rmdi_pkg::MODE_SWITCHING;
                end
            end
            rmdi_pkg::CMD_STOP:
            begin
                mode_next        = rmdi_pkg::MODE_STOPPED;
                current_dir_next = rmdi_pkg::DIR_NONE;
                pending_dir_next = rmdi_pkg::DIR_NONE;
                ticks_left_next  = '0;
            end
            rmdi_pkg::CMD_TICK:
            begin
                if (mode_reg == rmdi_pkg::MODE_SWITCHING)
                begin
                    ticks_left_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        current_dir_next = pending_dir_reg;
                        mode_next        = rmdi_pkg::MODE_RUNNING;
                    end
                end
            end
            default:
            begin
                status = rmdi_pkg::ST_PARAM;
            end
        endcase

        energized = (mode_next == rmdi_pkg::MODE_RUNNING) ? current_dir_next :
                    rmdi_pkg::DIR_NONE;

        res_next.status          = status;
        res_next.relay_cw_level  = (energized == rmdi_pkg::DIR_CW) ?
                                   relay_active_high_reg : !relay_active_high_reg;
        res_next.relay_ccw_level = (energized == rmdi_pkg::DIR_CCW) ?
                                   relay_active_high_reg : !relay_active_high_reg;
        res_next.motor_state     = mode_next;
        res_next.active_dir      = energized;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rmdi_pkg::MODE_STOPPED;
            current_dir_reg <= rmdi_pkg::DIR_NONE;
            pending_dir_reg <= rmdi_pkg::DIR_NONE;
            ticks_left_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                current_dir_reg <= current_dir_next;
                pending_dir_reg <= pending_dir_next;
                ticks_left_reg  <= ticks_left_next;
                res_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // The dead-time counter only holds a value while switching.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != rmdi_pkg::MODE_SWITCHING |-> ticks_left_reg == '0)
        else $error("dead-time counter nonzero outside switching");

    // A running motor always has a real direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rmdi_pkg::MODE_RUNNING |->
            (current_dir_reg == rmdi_pkg::DIR_CW || current_dir_reg == rmdi_pkg::DIR_CCW))
        else $error("running without a direction");

    // Switching always has a target direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rmdi_pkg::MODE_SWITCHING |->
            (pending_dir_reg == rmdi_pkg::DIR_CW || pending_dir_reg == rmdi_pkg::DIR_CCW))
        else $error("switching without a pending direction");

    // Relays are open in every result that is not running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.motor_state != rmdi_pkg::MODE_RUNNING) |->
            res_reg.active_dir == rmdi_pkg::DIR_NONE)
        else $error("relay energized while not running");

    // A stop request always leaves the motor stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.payload.command == rmdi_pkg::CMD_STOP) |=>
            (mode_reg == rmdi_pkg::MODE_STOPPED && current_dir_reg == rmdi_pkg::DIR_NONE))
        else $error("stop did not clear the state");
`endif

endmodule

`default_nettype wire
